[design/periodic_timer_table_defines.svh]
// Assertion macros used by the periodic timer table checker.
`ifndef PERIODIC_TIMER_TABLE_DEFINES_SVH
`define PERIODIC_TIMER_TABLE_DEFINES_SVH

// Consequent checked in the same cycle as the antecedent.
`define PTT_ASSERT_SAME(label, clk, rst_n, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

// Consequent checked in the cycle after the antecedent.
`define PTT_ASSERT_NEXT(label, clk, rst_n, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

[design/ptt_pkg.sv]
// Types and constants of the periodic timer table.
`timescale 1ns / 1ps
package ptt_pkg;

    localparam int OP_W        = 2;
    localparam int PERIOD_W    = 16;
    localparam int SLOT_W      = 4;
    localparam int COUNT_W     = 32;
    localparam int TAG_W       = 32;
    localparam int KIND_W      = 3;
    localparam int MAX_RESULTS = 16;
    localparam int RES_CNT_W   = 5;

    typedef enum logic [OP_W-1:0] {
        OP_TICK  = 2'd0,
        OP_START = 2'd1,
        OP_STOP  = 2'd2
    } op_e;

    typedef enum logic [KIND_W-1:0] {
        KIND_FIRED   = 3'd0,
        KIND_STARTED = 3'd1,
        KIND_STOPPED = 3'd2,
        KIND_FULL    = 3'd3,
        KIND_INVALID = 3'd4
    } kind_e;

    typedef enum logic [1:0] {
        ST_IDLE,
        ST_TICK,
        ST_FIND,
        ST_FLUSH
    } state_e;

    typedef struct packed {
        kind_e               kind;
        logic [SLOT_W-1:0]   timer_slot;
        logic [COUNT_W-1:0]  fire_count;
        logic [TAG_W-1:0]    user_tag;
        logic                last;
    } result_t;

endpackage

[design/ptt_req_if.sv]
// Request channel of the periodic timer table.
`timescale 1ns / 1ps
interface ptt_req_if import ptt_pkg::*; ();
    logic                valid;
    logic                ready;
    logic [OP_W-1:0]     op;
    logic [PERIOD_W-1:0] period;
    logic                single_shot;
    logic [TAG_W-1:0]    tag;
    logic [SLOT_W-1:0]   slot;

    modport source (output valid, op, period, single_shot, tag, slot, input ready);
    modport sink (input valid, op, period, single_shot, tag, slot, output ready);
endinterface

[design/ptt_rsp_if.sv]
// Result channel of the periodic timer table.
`timescale 1ns / 1ps
interface ptt_rsp_if import ptt_pkg::*; ();
    logic               valid;
    logic               ready;
    logic [KIND_W-1:0]  kind;
    logic [SLOT_W-1:0]  timer_slot;
    logic [COUNT_W-1:0] fire_count;
    logic [TAG_W-1:0]   user_tag;
    logic               last;

    modport source (output valid, kind, timer_slot, fire_count, user_tag, last, input ready);
    modport sink (input valid, kind, timer_slot, fire_count, user_tag, last, output ready);
endinterface

[design/ptt_entry_mem.sv]
// Timer entry memory: one write port, one read port with registered read data.
`timescale 1ns / 1ps
module ptt_entry_mem #(
    parameter int DEPTH = 16,
    parameter int WIDTH = 97,
    localparam int AW = $clog2(DEPTH)
) (
    input  logic             clk,
    input  logic             wr_en,
    input  logic [AW-1:0]    wr_addr,
    input  logic [WIDTH-1:0] wr_data,
    input  logic             rd_en,
    input  logic [AW-1:0]    rd_addr,
    output logic [WIDTH-1:0] rd_data
);

    logic [WIDTH-1:0] mem [DEPTH];
    logic [WIDTH-1:0] rd_data_reg;

    always_ff @(posedge clk)
    begin
        if (wr_en)
        begin
            mem[wr_addr] <= wr_data;
        end
    end

    always_ff @(posedge clk)
    begin
        if (rd_en)
        begin
            rd_data_reg <= mem[rd_addr];
        end
    end

    assign rd_data = rd_data_reg;

endmodule

[design/ptt_ctrl.sv]
// Sequencer of the timer table: request decode, slot walk, result buffering.
`timescale 1ns / 1ps
module ptt_ctrl import ptt_pkg::*; #(
    parameter int NUM_TIMERS = 16,
    parameter int TAG_BITS = 32,
    localparam int IW = $clog2(NUM_TIMERS),
    localparam int ENTRY_W = 2 * PERIOD_W + 1 + COUNT_W + TAG_BITS
) (
    input  logic               clk,
    input  logic               rst_n,
    ptt_req_if.sink            req,
    ptt_rsp_if.source          rsp,
    output logic               mem_wr_en,
    output logic [IW-1:0]      mem_wr_addr,
    output logic [ENTRY_W-1:0] mem_wr_data,
    output logic               mem_rd_en,
    output logic [IW-1:0]      mem_rd_addr,
    input  logic [ENTRY_W-1:0] mem_rd_data
);

    typedef struct packed {
        logic [PERIOD_W-1:0] reload;
        logic [PERIOD_W-1:0] remaining;
        logic                once;
        logic [COUNT_W-1:0]  shots;
        logic [TAG_BITS-1:0] tag;
    } entry_t;

    localparam logic [IW-1:0]      LAST_IDX  = IW'(NUM_TIMERS - 1);
    localparam logic [COUNT_W-1:0] SHOTS_MAX = {COUNT_W{1'b1}};

    state_e                  state_reg, state_next;
    logic [NUM_TIMERS-1:0]   live_reg, live_next;
    logic [IW-1:0]           rd_idx_reg, rd_idx_next;
    logic                    issue_done_reg, issue_done_next;
    logic                    p1_valid_reg, p1_valid_next;
    logic [IW-1:0]           p1_idx_reg, p1_idx_next;
    logic [RES_CNT_W-1:0]    res_cnt_reg, res_cnt_next;
    logic                    held_valid_reg, held_valid_next;
    result_t                 held_reg, held_next;
    logic                    out_valid_reg, out_valid_next;
    result_t                 out_reg, out_next;
    logic [PERIOD_W-1:0]     start_period_reg, start_period_next;
    logic                    start_once_reg, start_once_next;
    logic [TAG_BITS-1:0]     start_tag_reg, start_tag_next;

    entry_t                  rd_entry;
    entry_t                  wb_entry;
    logic [PERIOD_W-1:0]     rem_dec;
    logic                    p1_live;
    logic                    p1_fire;
    logic                    p1_emit;
    logic                    p1_stall;
    logic                    out_free;
    logic                    accept;
    logic                    walk_end;
    logic                    stop_ok;
    logic [IW-1:0]           stop_idx;

    assign rd_entry = entry_t'(mem_rd_data);
    assign rem_dec  = rd_entry.remaining - PERIOD_W'(1);
    assign p1_live  = live_reg[p1_idx_reg];
    assign p1_fire  = p1_valid_reg && p1_live && (rem_dec == '0);
    assign p1_emit  = p1_fire && (res_cnt_reg < RES_CNT_W'(MAX_RESULTS));
    assign out_free = !out_valid_reg || rsp.ready;
    // A new fired result can only be taken once the previous one has left the hold stage.
    assign p1_stall = (state_reg == ST_TICK) && p1_emit && held_valid_reg && !out_free;
    assign accept   = req.valid && req.ready;
    assign walk_end = (state_reg == ST_TICK) && issue_done_reg && p1_valid_reg && !p1_stall;
    assign stop_idx = IW'(req.slot);
    assign stop_ok  = (32'(req.slot) < NUM_TIMERS) && live_reg[stop_idx];

    always_comb
    begin
        wb_entry = rd_entry;
        if (p1_fire)
        begin
            if (!rd_entry.once)
            begin
                wb_entry.remaining = rd_entry.reload;
                wb_entry.shots = (rd_entry.shots == SHOTS_MAX) ? rd_entry.shots
                                                               : rd_entry.shots + COUNT_W'(1);
            end
            else
            begin
                wb_entry.remaining = rem_dec;
            end
        end
        else
        begin
            wb_entry.remaining = rem_dec;
        end
    end

    // Next state.
    always_comb
    begin
        state_next = state_reg;
        unique case (state_reg)
            ST_IDLE:
            begin
                if (accept)
                begin
                    unique case (req.op)
                        OP_TICK:  state_next = ST_TICK;
                        OP_START: state_next = ST_FIND;
                        OP_STOP:  state_next = ST_FLUSH;
                        default:  state_next = ST_IDLE;
                    endcase
                end
            end
            ST_TICK:
            begin
                if (walk_end)
                begin
                    state_next = held_valid_next ? ST_FLUSH : ST_IDLE;
                end
            end
            ST_FIND:
            begin
                if (!live_reg[rd_idx_reg] || (rd_idx_reg == LAST_IDX))
                begin
                    state_next = ST_FLUSH;
                end
            end
            ST_FLUSH:
            begin
                if (out_free)
                begin
                    state_next = ST_IDLE;
                end
            end
            default: state_next = ST_IDLE;
        endcase
    end

    // Outputs and datapath.
    always_comb
    begin
        live_next         = live_reg;
        rd_idx_next       = rd_idx_reg;
        issue_done_next   = issue_done_reg;
        p1_valid_next     = p1_valid_reg;
        p1_idx_next       = p1_idx_reg;
        res_cnt_next      = res_cnt_reg;
        held_valid_next   = held_valid_reg;
        held_next         = held_reg;
        out_valid_next    = out_valid_reg && !rsp.ready;
        out_next          = out_reg;
        start_period_next = start_period_reg;
        start_once_next   = start_once_reg;
        start_tag_next    = start_tag_reg;
        req.ready         = 1'b0;
        mem_wr_en         = 1'b0;
        mem_wr_addr       = p1_idx_reg;
        mem_wr_data       = ENTRY_W'(wb_entry);
        mem_rd_en         = 1'b0;
        mem_rd_addr       = rd_idx_reg;

        unique case (state_reg)
            ST_IDLE:
            begin
                req.ready = 1'b1;
                if (accept)
                begin
                    rd_idx_next     = '0;
                    issue_done_next = 1'b0;
                    p1_valid_next   = 1'b0;
                    res_cnt_next    = '0;
                    unique case (req.op)
                        OP_TICK:
                        begin
                        end
                        OP_START:
                        begin
                            start_period_next = req.period;
                            start_once_next   = req.single_shot;
                            start_tag_next    = TAG_BITS'(req.tag);
                        end
                        OP_STOP:
                        begin
                            held_valid_next      = 1'b1;
                            held_next.timer_slot = req.slot;
                            held_next.fire_count = '0;
                            held_next.user_tag   = '0;
                            held_next.last       = 1'b1;
                            if (stop_ok)
                            begin
                                held_next.kind     = KIND_STOPPED;
                                live_next[stop_idx] = 1'b0;
                            end
                            else
                            begin
                                held_next.kind = KIND_INVALID;
                            end
                        end
                        default:
                        begin
                        end
                    endcase
                end
            end
            ST_TICK:
            begin
                if (!p1_stall)
                begin
                    if (p1_valid_reg && p1_live)
                    begin
                        mem_wr_en = 1'b1;
                        if (p1_fire && rd_entry.once)
                        begin
                            live_next[p1_idx_reg] = 1'b0;
                        end
                    end
                    if (p1_emit)
                    begin
                        if (held_valid_reg)
                        begin
                            out_valid_next = 1'b1;
                            out_next       = held_reg;
                        end
                        held_valid_next      = 1'b1;
                        held_next.kind       = KIND_FIRED;
                        held_next.timer_slot = SLOT_W'(p1_idx_reg);
                        held_next.fire_count = rd_entry.shots;
                        held_next.user_tag   = TAG_W'(rd_entry.tag);
                        held_next.last       = 1'b0;
                        res_cnt_next         = res_cnt_reg + RES_CNT_W'(1);
                    end
                    // Reads run one slot ahead of the write-back, so they never meet.
                    if (!issue_done_reg)
                    begin
                        mem_rd_en       = 1'b1;
                        rd_idx_next     = rd_idx_reg + IW'(1);
                        issue_done_next = (rd_idx_reg == LAST_IDX);
                    end
                    p1_valid_next = !issue_done_reg;
                    p1_idx_next   = rd_idx_reg;
                end
            end
            ST_FIND:
            begin
                if (!live_reg[rd_idx_reg])
                begin
                    mem_wr_en               = 1'b1;
                    mem_wr_addr             = rd_idx_reg;
                    mem_wr_data             = {start_period_next, start_period_reg,
                                               start_once_reg, {COUNT_W{1'b0}}, start_tag_reg};
                    live_next[rd_idx_reg]   = 1'b1;
                    held_valid_next         = 1'b1;
                    held_next.kind          = KIND_STARTED;
                    held_next.timer_slot    = SLOT_W'(rd_idx_reg);
                    held_next.fire_count    = '0;
                    held_next.user_tag      = '0;
                    held_next.last          = 1'b1;
                end
                else if (rd_idx_reg == LAST_IDX)
                begin
                    held_valid_next      = 1'b1;
                    held_next.kind       = KIND_FULL;
                    held_next.timer_slot = '0;
                    held_next.fire_count = '0;
                    held_next.user_tag   = '0;
                    held_next.last       = 1'b1;
                end
                else
                begin
                    rd_idx_next = rd_idx_reg + IW'(1);
                end
            end
            ST_FLUSH:
            begin
                if (out_free)
                begin
                    out_valid_next  = 1'b1;
                    out_next        = held_reg;
                    out_next.last   = 1'b1;
                    held_valid_next = 1'b0;
                end
            end
            default:
            begin
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg      <= ST_IDLE;
            live_reg       <= '0;
            rd_idx_reg     <= '0;
            issue_done_reg <= 1'b0;
            p1_valid_reg   <= 1'b0;
            p1_idx_reg     <= '0;
            res_cnt_reg    <= '0;
            held_valid_reg <= 1'b0;
            out_valid_reg  <= 1'b0;
        end
        else
        begin
            state_reg      <= state_next;
            live_reg       <= live_next;
            rd_idx_reg     <= rd_idx_next;
            issue_done_reg <= issue_done_next;
            p1_valid_reg   <= p1_valid_next;
            p1_idx_reg     <= p1_idx_next;
            res_cnt_reg    <= res_cnt_next;
            held_valid_reg <= held_valid_next;
            out_valid_reg  <= out_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        held_reg         <= held_next;
        out_reg          <= out_next;
        start_period_reg <= start_period_next;
        start_once_reg   <= start_once_next;
        start_tag_reg    <= start_tag_next;
    end

    assign rsp.valid      = out_valid_reg;
    assign rsp.kind       = out_reg.kind;
    assign rsp.timer_slot = out_reg.timer_slot;
    assign rsp.fire_count = out_reg.fire_count;
    assign rsp.user_tag   = out_reg.user_tag;
    assign rsp.last       = out_reg.last;

endmodule

[design/periodic_timer_table.sv]
// Per item: a tick walks every slot of the table; a start scans the slots for the lowest free
// one (1 to NUM_TIMERS slots); a stop is resolved in the cycle it is accepted. An item's final
// result, if it has one, is registered as the block returns to idle, and a tick's earlier
// fired results leave at most one per cycle.
// Reset clears the live bits and the control state at once; the entry memory is not cleared,
// since an entry is used only while its live bit is set, and start writes it when setting that bit.
`timescale 1ns / 1ps
module periodic_timer_table import ptt_pkg::*; #(
    parameter int NUM_TIMERS = 16,
    parameter int TAG_BITS = 32
) (
    input  logic      clk,
    input  logic      rst_n,
    ptt_req_if.sink   req,
    ptt_rsp_if.source rsp
);

    localparam int IW = $clog2(NUM_TIMERS);
    localparam int ENTRY_W = 2 * PERIOD_W + 1 + COUNT_W + TAG_BITS;

    logic               mem_wr_en;
    logic [IW-1:0]      mem_wr_addr;
    logic [ENTRY_W-1:0] mem_wr_data;
    logic               mem_rd_en;
    logic [IW-1:0]      mem_rd_addr;
    logic [ENTRY_W-1:0] mem_rd_data;

    ptt_ctrl #(
        .NUM_TIMERS (NUM_TIMERS),
        .TAG_BITS   (TAG_BITS)
    ) u_ctrl (
        .clk         (clk),
        .rst_n       (rst_n),
        .req         (req),
        .rsp         (rsp),
        .mem_wr_en   (mem_wr_en),
        .mem_wr_addr (mem_wr_addr),
        .mem_wr_data (mem_wr_data),
        .mem_rd_en   (mem_rd_en),
        .mem_rd_addr (mem_rd_addr),
        .mem_rd_data (mem_rd_data)
    );

    ptt_entry_mem #(
        .DEPTH (NUM_TIMERS),
        .WIDTH (ENTRY_W)
    ) u_mem (
        .clk     (clk),
        .wr_en   (mem_wr_en),
        .wr_addr (mem_wr_addr),
        .wr_data (mem_wr_data),
        .rd_en   (mem_rd_en),
        .rd_addr (mem_rd_addr),
        .rd_data (mem_rd_data)
    );

endmodule

[design/ptt_checker.sv]
// Port-level checks of the periodic timer table and their binding.
`timescale 1ns / 1ps
`include "periodic_timer_table_defines.svh"
module ptt_checker import ptt_pkg::*; (
    input logic               clk,
    input logic               rst_n,
    input logic               req_valid,
    input logic               req_ready,
    input logic [OP_W-1:0]    req_op,
    input logic               rsp_valid,
    input logic               rsp_ready,
    input logic [KIND_W-1:0]  rsp_kind,
    input logic [SLOT_W-1:0]  rsp_timer_slot,
    input logic [COUNT_W-1:0] rsp_fire_count,
    input logic [TAG_W-1:0]   rsp_user_tag,
    input logic               rsp_last
);

    `PTT_ASSERT_NEXT(a_rsp_hold, clk, rst_n, rsp_valid && !rsp_ready, rsp_valid && $stable(rsp_kind) && $stable(rsp_timer_slot) && $stable(rsp_fire_count) && $stable(rsp_user_tag) && $stable(rsp_last), "result beat changed while stalled")
    `PTT_ASSERT_SAME(a_single_last, clk, rst_n, rsp_valid && (rsp_kind != KIND_FIRED), rsp_last && (rsp_fire_count == '0) && (rsp_user_tag == '0), "non-fired result is not a clean final beat")
    `PTT_ASSERT_SAME(a_full_slot, clk, rst_n, rsp_valid && (rsp_kind == KIND_FULL), rsp_timer_slot == '0, "table full result names a slot")
    `PTT_ASSERT_NEXT(a_busy_after_cmd, clk, rst_n, req_valid && req_ready && ((req_op == OP_START) || (req_op == OP_STOP)), !req_ready, "request taken while a start or stop is in work")

endmodule

bind periodic_timer_table ptt_checker u_ptt_checker (
    .clk            (clk),
    .rst_n          (rst_n),
    .req_valid      (req.valid),
    .req_ready      (req.ready),
    .req_op         (req.op),
    .rsp_valid      (rsp.valid),
    .rsp_ready      (rsp.ready),
    .rsp_kind       (rsp.kind),
    .rsp_timer_slot (rsp.timer_slot),
    .rsp_fire_count (rsp.fire_count),
    .rsp_user_tag   (rsp.user_tag),
    .rsp_last       (rsp.last)
);
